[rtl/lru_key_value_cache_assert.svh]
// Assertion macros for the cache.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define LKV_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define LKV_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

[rtl/lkvc_pkg.sv]
package lkvc_pkg;
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int KEY_BITS = 64;
  localparam int RVAL_BITS = 32;
  localparam int CNT_BITS = 7;
  localparam int ENTRIES = 64;
  localparam int VALUE_BITS = 32;
endpackage

[rtl/lkvc_if.sv]
interface lkvc_req_if;
  import lkvc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [KEY_BITS-1:0] lookup_key;
  logic [31:0]         new_value;
  modport source(output valid, func, lookup_key, new_value, input ready);
  modport sink(input valid, func, lookup_key, new_value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [RVAL_BITS-1:0] read_value;
  logic                 evicted;
  logic [CNT_BITS-1:0]  occupancy;
  modport source(output valid, hit, read_value, evicted, occupancy, input ready);
  modport sink(input valid, hit, read_value, evicted, occupancy, output ready);
endinterface

interface lkvc_cfg_if;
  import lkvc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[rtl/lru_key_value_cache.sv]
// LRU key/value cache, fully associative.
// Channels: req (func, lookup_key, new_value), rsp (hit, read_value, evicted,
// occupancy) and cfg (capacity, 7 bits, reset 64). All use valid/ready; an item
// moves on a clock edge where both are high. Write cfg only while idle.
// One item is worked at a time. A lookup or insert scans the key memory one slot
// per cycle, then takes the last registered read (S_LAST) and decides (S_DEC).
// A lookup miss goes on to the output. A hit or an eviction first reads links and
// value at the target (S_L1, S_L2); the recency list is relinked for a hit on an
// older entry or an eviction. A new or relinked entry then goes to the front (S_P1, S_P2).
// Clear, null-key and unused-code items go straight to the output.
// A new item is taken in the cycle after the result is taken.
// Reset empties the table at once (valid bits are flip-flops), clears the
// recency pointers and restores capacity to 64. The result sits in an output
// register; while the receiver stalls, it holds and no new item is taken.
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input logic clk,
  input logic rst,
  lkvc_req_if.sink req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink cfg
);
`include "lru_key_value_cache_assert.svh"
  localparam int SB = $clog2(ENTRIES);
  localparam int NB = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_LAST = 4'd2, S_DEC = 4'd3,
    S_L1 = 4'd4, S_L2 = 4'd5, S_P1 = 4'd6, S_P2 = 4'd7, S_OUT = 4'd8;

  logic [3:0] state;
  // memories
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [SB-1:0]         newer_mem [ENTRIES];
  logic [SB-1:0]         older_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid_bits;

  logic [CNT_BITS-1:0] capacity;
  logic [NB-1:0] count, cap_eff;
  logic [SB-1:0] mru, lru;
  logic [1:0] func;
  logic [KEY_BITS-1:0] key;
  logic [VALUE_BITS-1:0] nval;
  logic [SB-1:0] scan_idx;
  logic [SB-1:0] rd_addr, rd_q;
  logic rd_v;
  logic [KEY_BITS-1:0] key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SB-1:0] ln_rq, lo_rq;
  logic found, free_found;
  logic [SB-1:0] found_slot, free_slot, tgt, new_slot;
  logic evict_flag, was_empty;
  logic relink, need_evict, hit_now, free_now;

  logic out_hit, out_ev;
  logic [RVAL_BITS-1:0] out_val;

  // one write port per memory
  logic key_we, val_we;
  logic [SB-1:0] mem_wa;
  logic ln_we, lo_we;
  logic [SB-1:0] ln_wa, ln_wd, lo_wa, lo_wd;

  // Zero capacity acts as one, anything above the table size as the table size.
  always_comb begin
    if (capacity == '0) cap_eff = NB'(1);
    else if (int'(capacity) > ENTRIES) cap_eff = NB'(ENTRIES);
    else cap_eff = NB'(capacity);
  end

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  assign cfg.ready = 1'b1;
  assign rsp.occupancy = CNT_BITS'(count);
  assign rsp.hit = out_hit;
  assign rsp.evicted = out_ev;
  assign rsp.read_value = out_val;

  // A new key that does not fit pushes out the least recent entry.
  assign need_evict = (({1'b0, count} + (NB+1)'(1)) > {1'b0, cap_eff}) && (count != '0);
  // Compare the slot whose read landed this cycle.
  assign hit_now = rd_v && valid_bits[rd_q] && (key_q == key);
  assign free_now = rd_v && !valid_bits[rd_q];
  // After eviction the first free slot is the lower of the scan's free slot and
  // the victim.
  assign new_slot = (free_found && (free_slot < tgt)) ? free_slot : tgt;
  // Hit on the most recent entry needs no list change.
  assign relink = evict_flag || (tgt != mru);
  assign rd_addr = (state == S_SCAN) ? scan_idx : tgt;

  always_ff @(posedge clk) begin
    if (rst) capacity <= CNT_BITS'(64);
    else if (cfg.valid && cfg.ready) capacity <= cfg.data;
  end

  // memories, registered reads at one shared address
  always_ff @(posedge clk) begin
    if (key_we) key_mem[mem_wa] <= key;
    if (val_we) val_mem[mem_wa] <= nval;
    if (ln_we) newer_mem[ln_wa] <= ln_wd;
    if (lo_we) older_mem[lo_wa] <= lo_wd;
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
    ln_rq <= newer_mem[rd_addr];
    lo_rq <= older_mem[rd_addr];
    rd_q <= rd_addr;
  end

  // memory write sequencing
  always_comb begin
    key_we = 1'b0; val_we = 1'b0; mem_wa = tgt;
    ln_we = 1'b0; lo_we = 1'b0;
    ln_wa = tgt; ln_wd = tgt; lo_wa = tgt; lo_wd = mru;
    unique case (state)
      S_DEC: begin
        if (found) begin
          // update the value of a present key
          val_we = (func == FUNC_INSERT); mem_wa = found_slot;
        end else if (func == FUNC_INSERT && !need_evict) begin
          key_we = 1'b1; val_we = 1'b1; mem_wa = free_slot;
        end
      end
      S_L2: begin
        if (relink) begin
          // unlink tgt: bridge its neighbors
          lo_we = (tgt != mru); lo_wa = ln_rq; lo_wd = lo_rq;
          ln_we = (tgt != lru); ln_wa = lo_rq; ln_wd = ln_rq;
          // place the new entry once the victim is out
          key_we = evict_flag; val_we = evict_flag; mem_wa = new_slot;
        end
      end
      S_P1: begin
        if (!was_empty) begin
          lo_we = 1'b1; lo_wa = tgt; lo_wd = mru;
          ln_we = 1'b1; ln_wa = mru; ln_wd = tgt;
        end
      end
      S_P2: begin
        ln_we = 1'b1; ln_wa = tgt; ln_wd = tgt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid_bits <= '0;
      count <= '0;
      mru <= '0;
      lru <= '0;
      tgt <= '0;
      rsp.valid <= 1'b0;
      rd_v <= 1'b0;
      scan_idx <= '0;
    end else begin
      rd_v <= (state == S_SCAN);
      if (state == S_OUT) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            func <= req.func;
            key <= req.lookup_key;
            nval <= VALUE_BITS'(req.new_value);
            out_hit <= 1'b0; out_ev <= 1'b0; out_val <= '0;
            scan_idx <= '0;
            found <= 1'b0; free_found <= 1'b0; evict_flag <= 1'b0;
            if (req.func == FUNC_CLEAR) begin
              valid_bits <= '0; count <= '0; state <= S_OUT;
            end else if ((req.func == FUNC_LOOKUP || req.func == FUNC_INSERT)
                         && req.lookup_key != '0) begin
              state <= S_SCAN;
            end else begin
              // null key or unused code: answer with hit, evicted and value zero
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (hit_now && !found) begin
            found <= 1'b1; found_slot <= rd_q;
          end
          if (free_now && !free_found) begin
            free_found <= 1'b1; free_slot <= rd_q;
          end
          if (scan_idx == SB'(ENTRIES - 1)) state <= S_LAST;
          else scan_idx <= scan_idx + 1'b1;
        end
        S_LAST: begin
          // last registered read lands here
          if (hit_now && !found) begin
            found <= 1'b1; found_slot <= rd_q;
          end
          if (free_now && !free_found) begin
            free_found <= 1'b1; free_slot <= rd_q;
          end
          state <= S_DEC;
        end
        S_DEC: begin
          if (found) begin
            out_hit <= 1'b1;
            tgt <= found_slot;
            was_empty <= 1'b0;
            state <= S_L1;
          end else if (func == FUNC_LOOKUP) begin
            state <= S_OUT;
          end else if (need_evict) begin
            // drop the least recent entry first
            tgt <= lru; evict_flag <= 1'b1; out_ev <= 1'b1;
            state <= S_L1;
          end else begin
            tgt <= free_slot;
            valid_bits[free_slot] <= 1'b1;
            was_empty <= (count == '0);
            count <= count + 1'b1;
            state <= S_P1;
          end
        end
        S_L1: state <= S_L2; // link and value read issued at tgt
        S_L2: begin
          if (func == FUNC_LOOKUP) out_val <= RVAL_BITS'(val_q);
          if (relink) begin
            if (tgt == mru) mru <= lo_rq;
            if (tgt == lru) lru <= ln_rq;
            if (evict_flag) begin
              // victim out, new entry in; the count holds
              valid_bits <= (valid_bits & ~(ENTRIES'(1) << tgt))
                            | (ENTRIES'(1) << new_slot);
              tgt <= new_slot;
              was_empty <= (count == NB'(1));
            end
            state <= S_P1;
          end else begin
            state <= S_OUT;
          end
        end
        S_P1: begin
          if (was_empty) lru <= tgt;
          state <= S_P2;
        end
        S_P2: begin
          mru <= tgt;
          state <= S_OUT;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `LKV_ASSERT_IMPL(a_occ_bound, 1'b1, count <= NB'(ENTRIES))
  `LKV_ASSERT_NEXT(a_clear_empties, req.valid && req.ready && req.func == FUNC_CLEAR, count == '0)
  `LKV_ASSERT_IMPL(a_miss_zero, rsp.valid && !rsp.hit, rsp.read_value == '0)
  `LKV_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid)
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lkvc_pkg::*;

  localparam int SLOTS     = ENTRIES;
  localparam int MAX_ERR   = 10;
  localparam int CYC_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]          func;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         value;
  } op_t;

  typedef struct packed {
    logic                 hit;
    logic [RVAL_BITS-1:0] read_value;
    logic                 evicted;
    logic [CNT_BITS-1:0]  occupancy;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();
  lkvc_cfg_if cfg_if ();

  lru_key_value_cache i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source),
    .cfg (cfg_if.sink)
  );

  always #10 clk = ~clk;

  // Cache shadow: recency is kept as a queue of keys, most recent at the front.
  logic [KEY_BITS-1:0] recent_keys[$];
  logic [31:0]         shadow_value[logic [KEY_BITS-1:0]];
  int                  shadow_cap = 64;

  op_t     pending_ops[$];
  answer_t expected_answers[$];

  int     cycle_count  = 0;
  int     mismatches   = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_cycles  = 0;
  logic   req_fire     = 1'b0;

  // Predict one answer and advance the shadow.
  function automatic answer_t cache_predict(op_t op);
    answer_t a;
    int      idx[$];
    int      cap;
    a   = '0;
    cap = (shadow_cap < 1) ? 1 : (shadow_cap > SLOTS ? SLOTS : shadow_cap);
    if (op.func == FUNC_CLEAR) begin
      recent_keys.delete();
      shadow_value.delete();
    end else if ((op.func == FUNC_LOOKUP || op.func == FUNC_INSERT) && op.key != '0) begin
      idx = recent_keys.find_first_index(k) with (k == op.key);
      if (idx.size() > 0) begin
        // Hit: move to the front.
        recent_keys.delete(idx[0]);
        recent_keys.push_front(op.key);
        a.hit = 1'b1;
        if (op.func == FUNC_LOOKUP) begin
          a.read_value = shadow_value[op.key];
        end else begin
          shadow_value[op.key] = op.value;
        end
      end else if (op.func == FUNC_INSERT) begin
        // New key: drop the least recent once when over capacity.
        if (recent_keys.size() + 1 > cap && recent_keys.size() > 0) begin
          shadow_value.delete(recent_keys[$]);
          recent_keys.delete(recent_keys.size() - 1);
          a.evicted = 1'b1;
        end
        recent_keys.push_front(op.key);
        shadow_value[op.key] = op.value;
      end
    end
    a.occupancy = CNT_BITS'(recent_keys.size());
    return a;
  endfunction

  // Driver: advance on handshakes, change inputs at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid      <= 1'b1;
        req_if.func       <= pending_ops[0].func;
        req_if.lookup_key <= pending_ops[0].key;
        req_if.new_value  <= pending_ops[0].value;
        void'(pending_ops.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver ready; a long hold-off counts down in its own process.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Accepted requests feed the predictor.
  always @(posedge clk) begin
    op_t op;
    cycle_count <= cycle_count + 1;
    req_fire <= !rst && req_if.valid && req_if.ready;
    if (!rst && req_if.valid && req_if.ready) begin
      op.func  = req_if.func;
      op.key   = req_if.lookup_key;
      op.value = req_if.new_value;
      expected_answers.push_back(cache_predict(op));
    end
  end

  // Monitor: compare each accepted answer with the oldest expectation.
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.hit, rsp_if.read_value, rsp_if.evicted, rsp_if.occupancy};
      if (expected_answers.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_ERR) $display("unexpected answer %h", got);
      end else begin
        want = expected_answers.pop_front();
        if (got.hit !== want.hit || got.read_value !== want.read_value ||
            got.evicted !== want.evicted || got.occupancy !== want.occupancy) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_ERR)
            $display("answer mismatch: exp hit=%b val=%h ev=%b occ=%0d, %s",
                     want.hit, want.read_value, want.evicted, want.occupancy,
                     $sformatf("got hit=%b val=%h ev=%b occ=%0d",
                               got.hit, got.read_value, got.evicted, got.occupancy));
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Keys are drawn from a small pool so hits and evictions are frequent.
  function automatic logic [KEY_BITS-1:0] pick_key(int pool);
    logic [KEY_BITS-1:0] k;
    case ($urandom_range(9))
      0: k = {$urandom, $urandom};
      1: k = '0;
      default: k = KEY_BITS'($urandom_range(pool)) * 64'h9E37_79B9_7F4A_7C15 + 64'd1;
    endcase
    return k;
  endfunction

  task automatic queue_op(logic [1:0] f, logic [KEY_BITS-1:0] k, logic [31:0] v);
    pending_ops.push_back('{func: f, key: k, value: v});
  endtask

  task automatic queue_random(int count, int pool);
    int r;
    logic [1:0] f;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      f = (r < 45) ? FUNC_LOOKUP : (r < 93) ? FUNC_INSERT :
          (r < 97) ? FUNC_CLEAR : FUNC_UNUSED;
      queue_op(f, pick_key(pool), $urandom);
    end
  endtask

  // Wait until all queued items are answered, then let the block settle.
  task automatic drain();
    wait (pending_ops.size() == 0 && !req_if.valid);
    wait (expected_answers.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  // Write the capacity register while idle.
  task automatic write_capacity(logic [CNT_BITS-1:0] cap);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    shadow_cap = cap;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_LOOKUP;
    req_if.lookup_key = '0;
    req_if.new_value  = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: null keys, unused code, extremes, hits, update, clear.
    send_idle_pct = 31;
    recv_idle_pct = 86;
    queue_op(FUNC_LOOKUP, '0, '1);
    queue_op(FUNC_INSERT, '0, '1);
    queue_op(FUNC_UNUSED, '1, '1);
    queue_op(FUNC_INSERT, '1, '1);
    queue_op(FUNC_INSERT, 64'd1, '0);
    queue_op(FUNC_LOOKUP, '1, '0);
    queue_op(FUNC_LOOKUP, 64'd1, '0);
    queue_op(FUNC_INSERT, '1, 32'h5A5A_A5A5);
    queue_op(FUNC_LOOKUP, '1, '0);
    queue_op(FUNC_LOOKUP, 64'd2, '0);
    queue_op(FUNC_CLEAR, '1, '1);
    queue_op(FUNC_LOOKUP, '1, '0);
    drain();

    // Capacity one: every new key after the first evicts; then zero acts as one.
    write_capacity(7'd1);
    queue_op(FUNC_INSERT, 64'd7, 32'd70);
    queue_op(FUNC_INSERT, 64'd8, 32'd80);
    queue_op(FUNC_LOOKUP, 64'd7, '0);
    queue_op(FUNC_LOOKUP, 64'd8, '0);
    drain();
    write_capacity(7'd0);
    queue_random(60, 6);
    drain();

    // Fill to 64, then lower capacity below occupancy.
    write_capacity(7'd127);
    for (int i = 1; i <= 66; i++) queue_op(FUNC_INSERT, 64'(i) << 20, $urandom);
    drain();
    write_capacity(7'd5);
    queue_random(100, 90);
    drain();

    // Receiver holds off while the sender keeps offering.
    send_idle_pct = 86;
    recv_idle_pct = 31;
    write_capacity(7'd64);
    hold_cycles = 600;
    queue_random(180, 100);
    drain();
    write_capacity(7'd12);
    queue_random(150, 20);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(7'd33);
    queue_random(150, 45);
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_if.sv
rtl/lru_key_value_cache.sv
tb/sv/tb_top.sv
